// File: rtl/core/mf3_pkg.sv
package mf3_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 11;
    localparam int DIM_W      = 12;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int MIN_DIM    = 3;
    localparam int QUEUE_DEPTH = 4;

    // Register reset values
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_ANCHOR_MODE  = 2'd2
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;

    // Live configuration, raw register contents
    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic             anchor_mode;
    } cfg_t;

    // One window column, top to bottom (or sorted low to high)
    typedef struct packed {
        pix_t p0;
        pix_t p1;
        pix_t p2;
    } column_t;

    // Request from the front end: a complete window and its coordinate
    typedef struct packed {
        column_t            col_l;
        column_t            col_m;
        column_t            col_r;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               frame_end;
    } win_req_t;

    // Clamp a dimension register to 3..hi
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v < DIM_W'(MIN_DIM)) begin
            r = DIM_W'(MIN_DIM);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic pix_t pmin(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t pmax(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return pmax(pmin(a, b), pmin(pmax(a, b), c));
    endfunction

    // Sort three pixels, p0 lowest
    function automatic column_t sort3(input column_t c);
        column_t s;
        s.p0 = pmin(pmin(c.p0, c.p1), c.p2);
        s.p1 = med3(c.p0, c.p1, c.p2);
        s.p2 = pmax(pmax(c.p0, c.p1), c.p2);
        return s;
    endfunction

endpackage

// File: rtl/core/median_filter_3x3.sv
// Streaming 3x3 median filter for 8-bit grayscale pixels.
// Slave channel s_*: one pixel per request in raster order, one per clock while s_tready is high.
// Master channel m_*: one result per window that lies wholly in the frame,
// i.e. for every pixel outside rows 0..1 and columns 0..1; m_tlast marks
// the last result of a frame. Coordinates follow anchor_mode: window centre,
// or bottom-left corner of the window.
// Config channel cfg_*: index 0 frame_width, 1 frame_height, 2 anchor_mode;
// always ready, write only while the filter is idle. Dimensions are clamped
// to 3..2048.
// A result passes the read stage, the window queue, the column sort stage and
// the output register after its pixel is accepted. Throughput: one pixel per
// clock while s_tready is high, set by the single read and single write port of each line store.
// Reset (aresetn low, synchronous) clears the raster position, the window
// and all pipeline valids, and restores 640x480 centred. Line stores are not
// cleared; the first two rows of a frame fill them before they are used.
// When m_tready is low, results collect in the output stage, the column sort
// stage and a four-entry window queue; s_tready drops once those are full.
module median_filter_3x3 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] median, [18:8] out_row, [29:19] out_col
    output logic        m_tlast,   // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    mf3_pkg::cfg_t cfg_reg, cfg_next;

    logic                        push_valid, queue_full, req_valid, req_pop;
    mf3_pkg::win_req_t           push_req, pop_req;
    mf3_pkg::pix_t               median;
    logic [mf3_pkg::COORD_W-1:0] out_row, out_col;

    // Configuration register write decode
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (mf3_pkg::cfg_reg_t'(cfg_index))
                mf3_pkg::CFG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data;
                mf3_pkg::CFG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data;
                mf3_pkg::CFG_ANCHOR_MODE:  cfg_next.anchor_mode  = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= mf3_pkg::WIDTH_RESET;
            cfg_reg.frame_height <= mf3_pkg::HEIGHT_RESET;
            cfg_reg.anchor_mode  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: raster tracking, line stores, window
    mf3_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_pixel   (s_tdata),
        .push_valid (push_valid),
        .push_req   (push_req),
        .queue_full (queue_full)
    );

    // Window queue between front and back
    mf3_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_req  (push_req),
        .full      (queue_full),
        .pop       (req_pop),
        .not_empty (req_valid),
        .pop_req   (pop_req)
    );

    // Back: median pipeline and output register
    mf3_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (req_valid),
        .req_pop    (req_pop),
        .req        (pop_req),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_median (median),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_end    (m_tlast)
    );

    assign m_tdata = {2'b00, out_col, out_row, median};

endmodule

// File: rtl/core/mf3_ram.sv
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mf3_front.sv
module mf3_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  mf3_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  mf3_pkg::pix_t     in_pixel,
    output logic              push_valid,
    output mf3_pkg::win_req_t push_req,
    input  logic              queue_full
);

    // Raster position of the next pixel
    logic [mf3_pkg::COORD_W-1:0] row_reg, row_next;
    logic [mf3_pkg::COORD_W-1:0] col_reg, col_next;

    // Read stage: pixel waiting on its line store data
    logic                        a_valid_reg, a_valid_next;
    mf3_pkg::pix_t               a_px_reg;
    logic [mf3_pkg::ADDR_W-1:0]  a_addr_reg;
    logic                        a_res_reg;
    logic [mf3_pkg::COORD_W-1:0] a_orow_reg, a_ocol_reg;
    logic                        a_last_reg;

    // Two previous window columns
    mf3_pkg::column_t wl_reg, wm_reg;

    logic [mf3_pkg::DIM_W-1:0] w_lim, h_lim;
    logic                      accept, advance;
    logic                      last_col, last_row;
    mf3_pkg::pix_t             top_rd, mid_rd;

    assign w_lim = mf3_pkg::clamp_dim(cfg.frame_width, mf3_pkg::DIM_W'(mf3_pkg::MAX_WIDTH));
    assign h_lim = mf3_pkg::clamp_dim(cfg.frame_height, mf3_pkg::DIM_W'(mf3_pkg::MAX_HEIGHT));

    assign last_col = ({1'b0, col_reg} + mf3_pkg::DIM_W'(1)) >= w_lim;
    assign last_row = ({1'b0, row_reg} + mf3_pkg::DIM_W'(1)) >= h_lim;

    // Border pixels leave nothing for the queue
    assign advance  = a_valid_reg && (!a_res_reg || !queue_full);
    assign in_ready = !a_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // Position counters
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + mf3_pkg::COORD_W'(1);
            end else begin
                col_next = col_reg + mf3_pkg::COORD_W'(1);
            end
        end
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = 1'b1;
        end else if (advance) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            col_reg     <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            a_valid_reg <= a_valid_next;
        end
    end

    // Classify the pixel and latch its output coordinate
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_px_reg   <= in_pixel;
            a_addr_reg <= col_reg;
            a_res_reg  <= (row_reg >= mf3_pkg::COORD_W'(2)) && (col_reg >= mf3_pkg::COORD_W'(2));
            a_last_reg <= last_col && last_row;
            if (cfg.anchor_mode) begin
                a_orow_reg <= row_reg;
                a_ocol_reg <= col_reg - mf3_pkg::COORD_W'(2);
            end else begin
                a_orow_reg <= row_reg - mf3_pkg::COORD_W'(1);
                a_ocol_reg <= col_reg - mf3_pkg::COORD_W'(1);
            end
        end
    end

    // Line stores: a holds the row above, b the row two above
    mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(mf3_pkg::MAX_WIDTH)) u_line_a (
        .aclk  (aclk),
        .we    (advance),
        .waddr (a_addr_reg),
        .wdata (a_px_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(mf3_pkg::MAX_WIDTH)) u_line_b (
        .aclk  (aclk),
        .we    (advance),
        .waddr (a_addr_reg),
        .wdata (mid_rd),
        .re    (accept),
        .raddr (col_reg),
        .rdata (top_rd)
    );

    // Shift the window one column left
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg <= '0;
            wm_reg <= '0;
        end else if (advance) begin
            wl_reg <= wm_reg;
            wm_reg <= '{p0: top_rd, p1: mid_rd, p2: a_px_reg};
        end
    end

    assign push_valid         = a_valid_reg && a_res_reg && !queue_full;
    assign push_req.col_l     = wl_reg;
    assign push_req.col_m     = wm_reg;
    assign push_req.col_r     = '{p0: top_rd, p1: mid_rd, p2: a_px_reg};
    assign push_req.out_row   = a_orow_reg;
    assign push_req.out_col   = a_ocol_reg;
    assign push_req.frame_end = a_last_reg;

endmodule

// File: rtl/core/mf3_queue.sv
module mf3_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mf3_pkg::win_req_t push_req,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output mf3_pkg::win_req_t pop_req
);

    localparam int PTR_W = $clog2(mf3_pkg::QUEUE_DEPTH);

    mf3_pkg::win_req_t   mem_reg [mf3_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]      count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == (PTR_W+1)'(mf3_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_req   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (PTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// File: rtl/core/mf3_back.sv
module mf3_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_valid,
    output logic                        req_pop,
    input  mf3_pkg::win_req_t           req,
    output logic                        out_valid,
    input  logic                        out_ready,
    output mf3_pkg::pix_t               out_median,
    output logic [mf3_pkg::COORD_W-1:0] out_row,
    output logic [mf3_pkg::COORD_W-1:0] out_col,
    output logic                        out_end
);

    // Stage 1: each column sorted
    logic                        s1_valid_reg, s1_valid_next;
    mf3_pkg::column_t            s1_l_reg, s1_m_reg, s1_r_reg;
    logic [mf3_pkg::COORD_W-1:0] s1_row_reg, s1_col_reg;
    logic                        s1_end_reg;

    // Output register
    logic                        o_valid_reg, o_valid_next;
    mf3_pkg::pix_t               o_med_reg;
    logic [mf3_pkg::COORD_W-1:0] o_row_reg, o_col_reg;
    logic                        o_end_reg;

    logic          o_load, s1_load;
    mf3_pkg::pix_t lo3, md3, hi3;

    assign o_load  = s1_valid_reg && (!o_valid_reg || out_ready);
    assign s1_load = req_valid && (!s1_valid_reg || o_load);
    assign req_pop = s1_load;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s1_load) begin
            s1_valid_next = 1'b1;
        end else if (o_load) begin
            s1_valid_next = 1'b0;
        end
        o_valid_next = o_valid_reg;
        if (o_load) begin
            o_valid_next = 1'b1;
        end else if (out_ready) begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    // Column sort
    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_l_reg   <= mf3_pkg::sort3(req.col_l);
            s1_m_reg   <= mf3_pkg::sort3(req.col_m);
            s1_r_reg   <= mf3_pkg::sort3(req.col_r);
            s1_row_reg <= req.out_row;
            s1_col_reg <= req.out_col;
            s1_end_reg <= req.frame_end;
        end
    end

    // Max of lows, median of middles, min of highs, then their median
    assign lo3 = mf3_pkg::pmax(mf3_pkg::pmax(s1_l_reg.p0, s1_m_reg.p0), s1_r_reg.p0);
    assign md3 = mf3_pkg::med3(s1_l_reg.p1, s1_m_reg.p1, s1_r_reg.p1);
    assign hi3 = mf3_pkg::pmin(mf3_pkg::pmin(s1_l_reg.p2, s1_m_reg.p2), s1_r_reg.p2);

    always_ff @(posedge aclk) begin
        if (o_load) begin
            o_med_reg <= mf3_pkg::med3(lo3, md3, hi3);
            o_row_reg <= s1_row_reg;
            o_col_reg <= s1_col_reg;
            o_end_reg <= s1_end_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_median = o_med_reg;
    assign out_row    = o_row_reg;
    assign out_col    = o_col_reg;
    assign out_end    = o_end_reg;

endmodule

// File: dv/mf3_window_check.sv
`timescale 1ns / 1ps

// Watches the pixel, result and register channels of the median filter,
// mirrors its raster state and scores every result request in order.
module mf3_window_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [7:0] median, [18:8] out_row, [29:19] out_col
    input  logic        m_tlast,   // frame_end
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output int          errors,
    output int          pending
);
    import mf3_pkg::*;

    // Result word layout
    localparam int ROW_LSB = PIX_W;
    localparam int COL_LSB = PIX_W + COORD_W;
    localparam int PAD_LSB = PIX_W + 2 * COORD_W;
    localparam int PAD_W   = 32 - PAD_LSB;

    typedef struct packed {
        pix_t               median;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               frame_end;
    } filt_result_t;

    filt_result_t     due_q[$];
    pix_t             line_prev  [MAX_WIDTH];  // row above
    pix_t             line_prev2 [MAX_WIDTH];  // two rows above
    pix_t             col_hist   [6];          // older column 0..2, newer 3..5
    int               raster_row;
    int               raster_col;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             anchor_reg;
    int               fail_total = 0;

    function automatic int limit_dim(input logic [DIM_W-1:0] v, input int hi);
        int r;
        r = v;
        if (r < MIN_DIM) r = MIN_DIM;
        if (r > hi) r = hi;
        return r;
    endfunction

    // Median by rank: the value with at most four below it and more than
    // four at or below it
    function automatic pix_t median9(input logic [8:0][PIX_W-1:0] win);
        int   below;
        int   at_or_below;
        int   i;
        int   j;
        pix_t m;
        m = '0;
        for (i = 0; i < 9; i++) begin
            below = 0;
            at_or_below = 0;
            for (j = 0; j < 9; j++) begin
                if (win[j] < win[i]) below++;
                if (win[j] <= win[i]) at_or_below++;
            end
            if (below <= 4 && at_or_below > 4) m = win[i];
        end
        return m;
    endfunction

    task automatic check_field(input string what, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_v,
                     got_v);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        filt_result_t             want;
        logic [8:0][PIX_W-1:0]    win;
        pix_t                     px;
        pix_t                     top;
        pix_t                     mid;
        int                       w;
        int                       h;
        int                       ci;
        int                       i;
        bit                       last_col;
        bit                       last_row;
        if (!aresetn) begin
            due_q.delete();
            for (i = 0; i < MAX_WIDTH; i++) begin
                line_prev[i]  = '0;
                line_prev2[i] = '0;
            end
            for (i = 0; i < 6; i++) col_hist[i] = '0;
            raster_row = 0;
            raster_col = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            anchor_reg = 1'b0;
        end else begin
            // Register writes are to be made only while the filter is idle; this monitor applies them whenever taken
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_FRAME_WIDTH:  width_reg  = cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = cfg_data;
                    CFG_ANCHOR_MODE:  anchor_reg = cfg_data[0];
                    default: ;
                endcase
            end

            // Score each result request against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (due_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got %h last %b",
                             $time, m_tdata, m_tlast);
                    fail_total++;
                end else begin
                    want = due_q.pop_front();
                    check_field("median", want.median, m_tdata[PIX_W-1:0]);
                    check_field("out_row", want.row, m_tdata[ROW_LSB +: COORD_W]);
                    check_field("out_col", want.col, m_tdata[COL_LSB +: COORD_W]);
                    check_field("frame_end", want.frame_end, m_tlast);
                    check_field("tdata padding", 0, m_tdata[PAD_LSB +: PAD_W]);
                end
            end

            // Each pixel request completes a window column
            if (s_tvalid && s_tready) begin
                w   = limit_dim(width_reg, MAX_WIDTH);
                h   = limit_dim(height_reg, MAX_HEIGHT);
                ci  = (raster_col < MAX_WIDTH) ? raster_col : MAX_WIDTH - 1;
                px  = s_tdata;
                top = line_prev2[ci];
                mid = line_prev[ci];
                last_col = (raster_col + 1 >= w);
                last_row = (raster_row + 1 >= h);

                if (raster_row >= 2 && raster_col >= 2) begin
                    win = {px, col_hist[5], col_hist[2], mid, col_hist[4], col_hist[1],
                           top, col_hist[3], col_hist[0]};
                    want.median = median9(win);
                    if (anchor_reg) begin
                        want.row = COORD_W'(raster_row);
                        want.col = COORD_W'(raster_col - 2);
                    end else begin
                        want.row = COORD_W'(raster_row - 1);
                        want.col = COORD_W'(raster_col - 1);
                    end
                    want.frame_end = last_col && last_row;
                    due_q.push_back(want);
                end

                col_hist[0] = col_hist[3];
                col_hist[1] = col_hist[4];
                col_hist[2] = col_hist[5];
                col_hist[3] = top;
                col_hist[4] = mid;
                col_hist[5] = px;
                line_prev2[ci] = mid;
                line_prev[ci]  = px;

                // Raster wrap
                if (last_col) begin
                    raster_col = 0;
                    raster_row = last_row ? 0 : raster_row + 1;
                end else begin
                    raster_col = raster_col + 1;
                end
            end
        end
        errors  <= fail_total;
        pending <= due_q.size();
    end

endmodule

// File: dv/tb_median_filter_3x3.sv
`timescale 1ns / 1ps

module tb_median_filter_3x3;
    import mf3_pkg::*;

    localparam int RANDOM_ITEMS  = 1640;
    localparam int SETTLE_CYCLES = 10;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    int fail_count;
    int results_due;
    bit sender_idle;
    bit receiver_idle;
    int frame_w;
    int frame_h;

    median_filter_3x3 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mf3_window_check u_window_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (fail_count),
        .pending   (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("median_filter_3x3 verification failed");
        $finish;
    end

    // Result sink: random stall before each result request while receiver_idle is set
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = receiver_idle ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        int r;
        r = v;
        if (r < MIN_DIM) r = MIN_DIM;
        if (r > MAX_WIDTH) r = MAX_WIDTH;
        return r;
    endfunction

    function automatic pix_t next_pixel(input int flavour, input pix_t base);
        pix_t p;
        case (flavour)
            0: p = pix_t'($urandom_range(0, 255));
            1: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: p = base + pix_t'($urandom_range(0, 3));
            default: p = ($urandom_range(0, 7) == 0) ? pix_t'($urandom_range(0, 255)) : base;
        endcase
        return p;
    endfunction

    task automatic pick_idle();
        int mode;
        mode = $urandom_range(0, 3);
        sender_idle   = mode[0];
        receiver_idle = mode[1];
    endtask

    task automatic push_pixel(input pix_t p);
        int gap;
        gap = sender_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop sending and wait until every predicted result has come out
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers back to back, valid held high throughout
    task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic anchor);
        cfg_reg_t         idx [3];
        logic [DIM_W-1:0] val [3];
        int               i;
        idx[0] = CFG_FRAME_WIDTH;
        idx[1] = CFG_FRAME_HEIGHT;
        idx[2] = CFG_ANCHOR_MODE;
        val[0] = w;
        val[1] = h;
        val[2] = {{(DIM_W - 1){1'b0}}, anchor};
        hold_until_drained();
        for (i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        frame_w = eff_dim(w);
        frame_h = eff_dim(h);
    endtask

    task automatic send_frames(input int count, input int flavour);
        pix_t base;
        int   f;
        int   n;
        for (f = 0; f < count; f++) begin
            base = pix_t'($urandom_range(0, 255));
            for (n = 0; n < frame_w * frame_h; n++) push_pixel(next_pixel(flavour, base));
        end
    endtask

    initial begin : stimulus
        logic [71:0]      frame_a;
        logic [71:0]      frame_b;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        int               sel;
        int               frames;
        int               sent;
        int               i;

        frame_a = {8'h00, 8'h55, 8'hAA, 8'hFE, 8'h7F, 8'h80, 8'h01, 8'hFF, 8'h00};
        frame_b = {8'h80, 8'h80, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF};
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_FRAME_WIDTH;
        cfg_data      = '0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        frame_w       = eff_dim(WIDTH_RESET);
        frame_h       = eff_dim(HEIGHT_RESET);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: smallest frames from undersized registers, both anchors,
        // extreme and alternating pixel values with ties
        set_frame(12'd0, 12'd2, 1'b0);
        for (i = 0; i < 9; i++) push_pixel(frame_a[i * 8 +: 8]);
        set_frame(12'd2, 12'd0, 1'b1);
        for (i = 0; i < 9; i++) push_pixel(frame_b[i * 8 +: 8]);

        // Registers changed mid-frame: width lowered below the column
        // counter, then height lowered below the row counter
        set_frame(12'd8, 12'd6, 1'b0);
        pick_idle();
        for (i = 0; i < 29; i++) push_pixel(next_pixel(0, 8'h00));
        set_frame(12'd4, 12'd6, 1'b1);
        push_pixel(next_pixel(0, 8'h00));
        set_frame(12'd4, 12'd3, 1'b0);
        for (i = 0; i < 4; i++) push_pixel(next_pixel(0, 8'h00));

        // Random frame shapes, anchors, pixel content and idling
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) w = DIM_W'($urandom_range(0, 2));
            else if (sel == 1) w = DIM_W'($urandom_range(17, 64));
            else w = DIM_W'($urandom_range(3, 16));
            sel = $urandom_range(0, 19);
            if (sel == 0) h = DIM_W'($urandom_range(0, 2));
            else if (sel == 1) h = DIM_W'($urandom_range(9, 20));
            else h = DIM_W'($urandom_range(3, 8));
            set_frame(w, h, 1'($urandom_range(0, 1)));
            pick_idle();
            frames = $urandom_range(1, 3);
            send_frames(frames, $urandom_range(0, 3));
            sent += frames * frame_w * frame_h;
        end

        hold_until_drained();
        if (fail_count == 0 && results_due == 0) begin
            $display("median_filter_3x3 verification clean");
        end else begin
            $display("median_filter_3x3 verification failed");
        end
        $finish;
    end

endmodule
